FILE: src/pli_pkg.sv
// Package for the positional list core: operation and status codes,
// sequencer states and fixed field widths. No dependencies.
package pli_pkg;

  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } pli_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BEYOND  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } pli_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_FINISH,
    S_DONE
  } pli_state_e;

endpackage

FILE: src/pli_store.sv
// Entry store of the positional list: one write port and one read port,
// read data registered. Depends on no package.
module pli_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pli_step.sv
// Shared step unit of the positional list sequencer: adds or subtracts one.
// Serves index stepping and count updates. Depends on no package.
module pli_step #(
  parameter int unsigned W = 5
) (
  input  logic [W-1:0] a_i,
  input  logic         dec_i,
  output logic [W-1:0] sum_o
);

  always_comb begin
    if (dec_i) begin
      sum_o = a_i - W'(1);
    end else begin
      sum_o = a_i + W'(1);
    end
  end

endmodule

FILE: src/positional_list_insert_delete_core.sv
// Top level of the positional list core: sequencer, output register and
// instances of pli_store and pli_step. Depends on pli_pkg.
//
// Keeps a packed list of up to CAPACITY signed 32-bit entries and a fill
// count. Each input transaction is a write or append, an insert, a delete or
// a read at a zero-based position, and yields exactly one result transaction
// with a status, the read value (zero unless a read succeeds) and the count
// after the operation; a failed operation leaves the list unchanged. One
// transaction is worked on at a time. An insert or delete moves N entries,
// where N is count - position for an insert and count - position - 1 for a
// delete, one entry per cycle through the store's single read port and
// single write port. A finished result waits in an output register, and
// the next transaction is accepted meanwhile.
module positional_list_insert_delete_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [pli_pkg::POS_W-1:0]  position_i,
  input  logic signed [pli_pkg::DATA_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic signed [pli_pkg::DATA_W-1:0] read_value_o,
  output logic [pli_pkg::CNT_W-1:0]  count_o
);

  import pli_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned OW = (XW > CNT_W) ? XW : CNT_W;

  pli_state_e  state_q, state_d;
  pli_op_e     op_q, op_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CW-1:0]     count_q, count_d;
  logic [XW-1:0]     src_q, src_d;
  logic [XW-1:0]     dst_q, dst_d;
  logic [XW-1:0]     wra_q, wra_d;
  logic [XW-1:0]     lim_q, lim_d;
  logic              more_q, more_d;
  logic              pend_q, pend_d;
  pli_status_e       st_q, st_d;
  logic              out_valid_q, out_valid_d;
  pli_status_e       out_status_q, out_status_d;
  logic [DATA_W-1:0] out_rdval_q, out_rdval_d;
  logic [CW-1:0]     out_count_q, out_count_d;

  logic [XW-1:0]     pos_x, cnt_x, cap_x;
  pli_status_e       dec_status;
  logic [XW-1:0]     step_a, step_sum;
  logic              step_dec;
  logic              mem_we, mem_re;
  logic [XW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              accept, out_free;
  logic [OW-1:0]     out_count_x;

  assign pos_x    = XW'(pos_q);
  assign cnt_x    = XW'(count_q);
  assign cap_x    = XW'(CAPACITY);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (op_q)
      OP_WRITE: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_BEYOND;
        end else if (pos_x >= cap_x) begin
          dec_status = ST_FULL;
        end else begin
          dec_status = ST_OK;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_BEYOND;
        end else if (cnt_x >= cap_x) begin
          dec_status = ST_FULL;
        end else begin
          dec_status = ST_OK;
        end
      end
      default: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_MISSING;
        end else begin
          dec_status = ST_OK;
        end
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_DECODE: begin
        step_a   = (op_q == OP_DELETE) ? pos_x : cnt_x;
        step_dec = (op_q == OP_INSERT);
      end
      S_MOVE: begin
        step_a   = src_q;
        step_dec = (op_q == OP_INSERT);
      end
      S_FINISH: begin
        step_a   = cnt_x;
        step_dec = (op_q == OP_DELETE);
      end
      default: begin
        step_a   = cnt_x;
        step_dec = 1'b0;
      end
    endcase
  end

  pli_step #(
    .W (XW)
  ) u_step (
    .a_i   (step_a),
    .dec_i (step_dec),
    .sum_o (step_sum)
  );

  pli_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dec_status != ST_OK) begin
          state_d = S_DONE;
        end else if (op_q == OP_INSERT || op_q == OP_DELETE) begin
          state_d = S_MOVE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOVE: begin
        if (!more_q && !pend_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d         = op_q;
    pos_d        = pos_q;
    val_d        = val_q;
    count_d      = count_q;
    src_d        = src_q;
    dst_d        = dst_q;
    wra_d        = wra_q;
    lim_d        = lim_q;
    more_d       = more_q;
    pend_d       = pend_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_rdval_d  = out_rdval_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_x;
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = pos_x;
    in_ready_o   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = pli_op_e'(operation_i);
          pos_d = position_i;
          val_d = value_i;
        end
      end
      S_DECODE: begin
        st_d   = dec_status;
        more_d = 1'b0;
        pend_d = 1'b0;
        if (dec_status == ST_OK) begin
          unique case (op_q)
            OP_WRITE: begin
              mem_we = 1'b1;
              if (pos_x == cnt_x) begin
                count_d = step_sum[CW-1:0];
              end
            end
            OP_READ: begin
              mem_re = 1'b1;
            end
            OP_INSERT: begin
              src_d  = step_sum;
              dst_d  = cnt_x;
              lim_d  = pos_x;
              more_d = (cnt_x != pos_x);
            end
            default: begin
              src_d  = step_sum;
              dst_d  = pos_x;
              lim_d  = cnt_x;
              more_d = (step_sum != cnt_x);
            end
          endcase
        end
      end
      S_MOVE: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wra_q;
          mem_wdata = mem_rdata;
        end
        if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = src_q;
          wra_d     = dst_q;
          dst_d     = src_q;
          src_d     = step_sum;
          pend_d    = 1'b1;
          more_d    = (op_q == OP_INSERT) ? (src_q != lim_q) : (step_sum != lim_q);
        end else begin
          pend_d = 1'b0;
        end
      end
      S_FINISH: begin
        if (op_q == OP_INSERT) begin
          mem_we = 1'b1;
        end
        count_d = step_sum[CW-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_count_d  = count_q;
          if (op_q == OP_READ && st_q == ST_OK) begin
            out_rdval_d = mem_rdata;
          end else begin
            out_rdval_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    wra_q        <= wra_d;
    lim_q        <= lim_d;
    st_q         <= st_d;
    out_status_q <= out_status_d;
    out_rdval_q  <= out_rdval_d;
    out_count_q  <= out_count_d;
  end

  assign out_count_x  = OW'(out_count_q);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_rdval_q;
  assign count_o      = out_count_x[CNT_W-1:0];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= cap_x)
    else $error("fill count above capacity");

  a_pend_in_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_MOVE))
    else $error("pending entry move outside move phase");

  a_rdval_only_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || read_value_o == '0))
    else $error("nonzero read value on failed operation");

  a_fail_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE && dec_status != ST_OK) |=> (count_q == $past(count_q)))
    else $error("failed operation changed the count");

endmodule
